FILE: rtl/core/t6502_pkg.sv
// shared types, opcodes and constants for the tiny 6502 bus cycle core
package t6502_pkg;

  localparam logic [2:0] RESET_WAIT_TICKS = 3'd7;

  localparam logic [15:0] VEC_LO_ADDR = 16'hFFFC;
  localparam logic [15:0] VEC_HI_ADDR = 16'hFFFD;
  localparam logic [7:0]  STATUS_RESET = 8'h34;

  localparam logic [7:0] OP_NOP     = 8'hEA;
  localparam logic [7:0] OP_DEX     = 8'hCA;
  localparam logic [7:0] OP_LDA_IMM = 8'hA9;
  localparam logic [7:0] OP_LDX_IMM = 8'hA2;
  localparam logic [7:0] OP_BNE     = 8'hD0;
  localparam logic [7:0] OP_JMP_ABS = 8'h4C;
  localparam logic [7:0] OP_STA_ABS = 8'h8D;
  localparam logic [7:0] OP_LDA_ABS = 8'hAD;

  localparam int FLAG_Z_BIT = 1;
  localparam int FLAG_N_BIT = 7;

  typedef enum logic [8:0] {
    PH_RES_HOLD = 9'b000000001,
    PH_RES_WAIT = 9'b000000010,
    PH_VEC_LO   = 9'b000000100,
    PH_VEC_HI   = 9'b000001000,
    PH_FETCH    = 9'b000010000,
    PH_IMM      = 9'b000100000,
    PH_ADR_LO   = 9'b001000000,
    PH_ADR_HI   = 9'b010000000,
    PH_DATA     = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [7:0]  data_in;
    logic        reset_n;
    logic        ready_req;
    logic        bus_enable;
  } tick_t;

  typedef struct packed {
    logic        bus_released;
    logic        drive_data;
    logic [7:0]  data_out;
    logic        vector_pull_n;
    logic        sync;
    logic        read_not_write;
    logic [15:0] address;
  } pins_t;

  function automatic logic [7:0] set_zn(input logic [7:0] flags, input logic [7:0] val);
    logic [7:0] f;
    f = flags;
    f[FLAG_Z_BIT] = (val == 8'h00);
    f[FLAG_N_BIT] = val[7];
    return f;
  endfunction

endpackage

FILE: rtl/core/tiny_6502_bus_cycle_core.sv
// tiny 6502 bus cycle core: one bus tick per item, one pin result per item
// each accepted tick's result is registered in the output register
// throughput: one tick per clock while m_tready keeps up; at most one state step per tick
// the next tick is taken while the result waits, as long as m_tready frees the register
// rst clears the cpu state to its power-up values (reset hold phase) and empties the output
module tiny_6502_bus_cycle_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // bus_enable, ready_req, reset_n, data_in[7:0], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // address[15:0], read_not_write, sync, vector_pull_n,
                                 // data_out[7:0], drive_data, bus_released, zero pad
);
  import t6502_pkg::*;

  logic [7:0]  accumulator, accumulator_next;
  logic [7:0]  index_x, index_x_next;
  logic [7:0]  status_flags, status_flags_next;
  logic [15:0] program_counter, program_counter_next;
  logic [15:0] address_latch, address_latch_next;
  logic [15:0] effective_address, effective_address_next;
  logic [7:0]  opcode_reg, opcode_reg_next;
  logic [2:0]  reset_wait_count, reset_wait_count_next;
  phase_t      cycle_phase, cycle_phase_next;
  logic        read_flag, read_flag_next;
  logic        sync_flag, sync_flag_next;

  tick_t       tick;
  pins_t       pins_next;
  pins_t       pins;
  logic        accept;
  logic [15:0] pc_inc;
  logic [15:0] branch_off;

  assign tick     = tick_t'(s_tdata[10:0]);
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign pc_inc   = program_counter + 16'd1;
  assign branch_off = {{8{tick.data_in[7]}}, tick.data_in};

  always_comb begin
    accumulator_next       = accumulator;
    index_x_next           = index_x;
    status_flags_next      = status_flags;
    program_counter_next   = program_counter;
    address_latch_next     = address_latch;
    effective_address_next = effective_address;
    opcode_reg_next        = opcode_reg;
    reset_wait_count_next  = reset_wait_count;
    cycle_phase_next       = cycle_phase;
    read_flag_next         = read_flag;
    sync_flag_next         = sync_flag;

    if (!tick.reset_n) begin
      cycle_phase_next      = PH_RES_HOLD;
      reset_wait_count_next = RESET_WAIT_TICKS;
      sync_flag_next        = 1'b0;
      read_flag_next        = 1'b1;
      address_latch_next    = VEC_LO_ADDR;
    end else if (tick.bus_enable && tick.ready_req) begin
      case (cycle_phase)
        PH_RES_WAIT: begin
          if (reset_wait_count <= 3'd1) begin
            reset_wait_count_next = 3'd0;
            cycle_phase_next      = PH_VEC_LO;
            address_latch_next    = VEC_LO_ADDR;
            read_flag_next        = 1'b1;
            sync_flag_next        = 1'b0;
          end else begin
            reset_wait_count_next = reset_wait_count - 3'd1;
          end
        end
        PH_VEC_LO: begin
          program_counter_next = {8'h00, tick.data_in};
          cycle_phase_next     = PH_VEC_HI;
          address_latch_next   = VEC_HI_ADDR;
          read_flag_next       = 1'b1;
          sync_flag_next       = 1'b0;
        end
        PH_VEC_HI: begin
          program_counter_next = {tick.data_in, program_counter[7:0]};
          cycle_phase_next     = PH_FETCH;
          address_latch_next   = {tick.data_in, program_counter[7:0]};
          read_flag_next       = 1'b1;
          sync_flag_next       = 1'b1;
        end
        PH_FETCH: begin
          opcode_reg_next      = tick.data_in;
          program_counter_next = pc_inc;
          address_latch_next   = pc_inc;
          read_flag_next       = 1'b1;
          sync_flag_next       = 1'b0;
          case (tick.data_in)
            OP_DEX: begin
              index_x_next      = index_x - 8'd1;
              status_flags_next = set_zn(status_flags, index_x - 8'd1);
              cycle_phase_next  = PH_FETCH;
              sync_flag_next    = 1'b1;
            end
            OP_LDA_IMM, OP_LDX_IMM, OP_BNE: cycle_phase_next = PH_IMM;
            OP_JMP_ABS, OP_STA_ABS, OP_LDA_ABS: cycle_phase_next = PH_ADR_LO;
            default: begin
              // nop and unknown opcodes
              cycle_phase_next = PH_FETCH;
              sync_flag_next   = 1'b1;
            end
          endcase
        end
        PH_IMM: begin
          program_counter_next = pc_inc;
          if (opcode_reg == OP_LDX_IMM) begin
            index_x_next      = tick.data_in;
            status_flags_next = set_zn(status_flags, tick.data_in);
          end else if (opcode_reg == OP_BNE) begin
            if (!status_flags[FLAG_Z_BIT]) program_counter_next = pc_inc + branch_off;
          end else begin
            accumulator_next  = tick.data_in;
            status_flags_next = set_zn(status_flags, tick.data_in);
          end
          cycle_phase_next   = PH_FETCH;
          address_latch_next = program_counter_next;
          read_flag_next     = 1'b1;
          sync_flag_next     = 1'b1;
        end
        PH_ADR_LO: begin
          effective_address_next = {8'h00, tick.data_in};
          program_counter_next   = pc_inc;
          cycle_phase_next       = PH_ADR_HI;
          address_latch_next     = pc_inc;
          read_flag_next         = 1'b1;
        end
        PH_ADR_HI: begin
          effective_address_next = {tick.data_in, effective_address[7:0]};
          if (opcode_reg == OP_JMP_ABS) begin
            program_counter_next = {tick.data_in, effective_address[7:0]};
            cycle_phase_next     = PH_FETCH;
            address_latch_next   = {tick.data_in, effective_address[7:0]};
            read_flag_next       = 1'b1;
            sync_flag_next       = 1'b1;
          end else begin
            program_counter_next = pc_inc;
            cycle_phase_next     = PH_DATA;
            address_latch_next   = {tick.data_in, effective_address[7:0]};
            read_flag_next       = (opcode_reg != OP_STA_ABS);
            sync_flag_next       = 1'b0;
          end
        end
        PH_DATA: begin
          if (read_flag) begin
            accumulator_next  = tick.data_in;
            status_flags_next = set_zn(status_flags, tick.data_in);
          end
          cycle_phase_next   = PH_FETCH;
          address_latch_next = program_counter;
          read_flag_next     = 1'b1;
          sync_flag_next     = 1'b1;
        end
        default: begin
          // reset hold
          cycle_phase_next      = PH_RES_WAIT;
          reset_wait_count_next = RESET_WAIT_TICKS;
          address_latch_next    = VEC_LO_ADDR;
          read_flag_next        = 1'b1;
          sync_flag_next        = 1'b0;
        end
      endcase
    end

    if (!tick.bus_enable) begin
      pins_next              = '0;
      pins_next.bus_released = 1'b1;
    end else begin
      pins_next.address        = address_latch_next;
      pins_next.read_not_write = read_flag_next;
      pins_next.sync           = sync_flag_next;
      pins_next.vector_pull_n  = !(cycle_phase_next == PH_VEC_LO ||
                                   cycle_phase_next == PH_VEC_HI);
      pins_next.data_out       = read_flag_next ? 8'h00 : accumulator_next;
      pins_next.drive_data     = !read_flag_next;
      pins_next.bus_released   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator       <= 8'h00;
      index_x           <= 8'h00;
      status_flags      <= STATUS_RESET;
      program_counter   <= 16'h0000;
      address_latch     <= VEC_LO_ADDR;
      effective_address <= 16'h0000;
      opcode_reg        <= 8'h00;
      reset_wait_count  <= RESET_WAIT_TICKS;
      cycle_phase       <= PH_RES_HOLD;
      read_flag         <= 1'b1;
      sync_flag         <= 1'b0;
      m_tvalid          <= 1'b0;
    end else begin
      if (accept) begin
        accumulator       <= accumulator_next;
        index_x           <= index_x_next;
        status_flags      <= status_flags_next;
        program_counter   <= program_counter_next;
        address_latch     <= address_latch_next;
        effective_address <= effective_address_next;
        opcode_reg        <= opcode_reg_next;
        reset_wait_count  <= reset_wait_count_next;
        cycle_phase       <= cycle_phase_next;
        read_flag         <= read_flag_next;
        sync_flag         <= sync_flag_next;
        m_tvalid          <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) pins <= pins_next;
  end

  assign m_tdata = {3'b000, pins};

  // sync is only shown when the next cycle is an opcode fetch
  a_sync_fetch: assert property (@(posedge clk) disable iff (rst)
    sync_flag |-> cycle_phase == PH_FETCH)
    else $error("sync set outside fetch phase");

  // a write cycle only happens in the data phase of a store
  a_write_store: assert property (@(posedge clk) disable iff (rst)
    !read_flag |-> (cycle_phase == PH_DATA && opcode_reg == OP_STA_ABS))
    else $error("write cycle outside store data phase");

  // a driven tick with reset low shows the reset vector address next
  a_reset_pins: assert property (@(posedge clk) disable iff (rst)
    (accept && !tick.reset_n && tick.bus_enable) |=>
      (m_tvalid && pins.address == VEC_LO_ADDR && !pins.sync && pins.read_not_write))
    else $error("reset tick did not show the vector address");

  // a released bus result carries nothing else
  a_released_quiet: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && pins.bus_released) |-> (pins.address == 16'h0000 && !pins.drive_data))
    else $error("released bus result drives pins");

endmodule

FILE: sim/tiny_6502_bus_cycle_core_tb.sv
// testbench for tiny_6502_bus_cycle_core: bus tick stimulus with a cycle-level cpu predictor
module tiny_6502_bus_cycle_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import t6502_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  tiny_6502_bus_cycle_core dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  // cpu state as seen by the predictor
  logic [7:0]  acc_r;
  logic [7:0]  x_r;
  logic [7:0]  flags_r;
  logic [15:0] pc_r;
  logic [15:0] bus_addr_r;
  logic [15:0] eff_addr_r;
  logic [7:0]  opcode_r;
  logic [2:0]  wait_cnt_r;
  phase_t      phase_r;
  logic        read_r;
  logic        sync_r;

  pins_t pins_q[$];
  int    errors = 0;
  bit    no_gaps = 1'b0;
  bit    hold_req = 1'b0;

  logic [7:0] known_ops[8] = '{OP_NOP, OP_DEX, OP_LDA_IMM, OP_LDX_IMM,
                               OP_BNE, OP_JMP_ABS, OP_STA_ABS, OP_LDA_ABS};

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    errors++;
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
  endtask

  function automatic void set_zn_flags(input logic [7:0] v);
    flags_r[FLAG_Z_BIT] = (v == 8'h00);
    flags_r[FLAG_N_BIT] = v[7];
  endfunction

  function automatic void begin_fetch();
    phase_r    = PH_FETCH;
    bus_addr_r = pc_r;
    read_r     = 1'b1;
    sync_r     = 1'b1;
  endfunction

  function automatic void enter_wait();
    wait_cnt_r = RESET_WAIT_TICKS;
    bus_addr_r = VEC_LO_ADDR;
    read_r     = 1'b1;
    sync_r     = 1'b0;
  endfunction

  function automatic void advance_cpu(input logic [7:0] d);
    case (phase_r)
      PH_RES_WAIT: begin
        if (wait_cnt_r <= 3'd1) begin
          wait_cnt_r = 3'd0;
          phase_r    = PH_VEC_LO;
          bus_addr_r = VEC_LO_ADDR;
          read_r     = 1'b1;
          sync_r     = 1'b0;
        end else begin
          wait_cnt_r = wait_cnt_r - 3'd1;
        end
      end
      PH_VEC_LO: begin
        pc_r       = {8'h00, d};
        phase_r    = PH_VEC_HI;
        bus_addr_r = VEC_HI_ADDR;
        read_r     = 1'b1;
        sync_r     = 1'b0;
      end
      PH_VEC_HI: begin
        pc_r = {d, pc_r[7:0]};
        begin_fetch();
      end
      PH_FETCH: begin
        opcode_r = d;
        pc_r     = pc_r + 16'd1;
        sync_r   = 1'b0;
        case (d)
          OP_DEX: begin
            x_r = x_r - 8'd1;
            set_zn_flags(x_r);
            begin_fetch();
          end
          OP_LDA_IMM, OP_LDX_IMM, OP_BNE: begin
            phase_r    = PH_IMM;
            bus_addr_r = pc_r;
            read_r     = 1'b1;
          end
          OP_JMP_ABS, OP_STA_ABS, OP_LDA_ABS: begin
            phase_r    = PH_ADR_LO;
            bus_addr_r = pc_r;
            read_r     = 1'b1;
          end
          default: begin_fetch();
        endcase
      end
      PH_IMM: begin
        pc_r = pc_r + 16'd1;
        if (opcode_r == OP_LDX_IMM) begin
          x_r = d;
          set_zn_flags(x_r);
        end else if (opcode_r == OP_BNE) begin
          if (!flags_r[FLAG_Z_BIT]) pc_r = pc_r + {{8{d[7]}}, d};
        end else begin
          acc_r = d;
          set_zn_flags(acc_r);
        end
        begin_fetch();
      end
      PH_ADR_LO: begin
        eff_addr_r = {8'h00, d};
        pc_r       = pc_r + 16'd1;
        phase_r    = PH_ADR_HI;
        bus_addr_r = pc_r;
        read_r     = 1'b1;
      end
      PH_ADR_HI: begin
        eff_addr_r = {d, eff_addr_r[7:0]};
        pc_r       = pc_r + 16'd1;
        if (opcode_r == OP_JMP_ABS) begin
          pc_r = eff_addr_r;
          begin_fetch();
        end else begin
          phase_r    = PH_DATA;
          bus_addr_r = eff_addr_r;
          read_r     = (opcode_r != OP_STA_ABS);
          sync_r     = 1'b0;
        end
      end
      PH_DATA: begin
        if (read_r) begin
          acc_r = d;
          set_zn_flags(acc_r);
        end
        begin_fetch();
      end
      default: begin
        phase_r = PH_RES_WAIT;
        enter_wait();
      end
    endcase
  endfunction

  function automatic pins_t step_cpu(input tick_t t);
    pins_t p;
    if (!t.reset_n) begin
      phase_r = PH_RES_HOLD;
      enter_wait();
    end else if (t.bus_enable && t.ready_req) begin
      advance_cpu(t.data_in);
    end
    p = '0;
    if (!t.bus_enable) begin
      p.bus_released = 1'b1;
    end else begin
      p.address        = bus_addr_r;
      p.read_not_write = read_r;
      p.sync           = sync_r;
      p.vector_pull_n  = !(phase_r == PH_VEC_LO || phase_r == PH_VEC_HI);
      p.data_out       = read_r ? 8'h00 : acc_r;
      p.drive_data     = !read_r;
    end
    return p;
  endfunction

  function automatic tick_t make_tick(input logic be, input logic rdy, input logic rst_n,
                                      input logic [7:0] d);
    tick_t t;
    t.bus_enable = be;
    t.ready_req  = rdy;
    t.reset_n    = rst_n;
    t.data_in    = d;
    return t;
  endfunction

  // opcodes mostly from the implemented set so programs run deep
  function automatic tick_t random_tick();
    int unsigned r;
    logic [7:0] d;
    r = $urandom_range(0, 99);
    if (phase_r == PH_FETCH && $urandom_range(0, 99) < 85)
      d = known_ops[$urandom_range(0, 7)];
    else
      d = 8'($urandom);
    if (r < 4) return make_tick(1'b0, 1'b1, 1'b1, d);
    if (r < 9) return make_tick(1'b1, 1'b0, 1'b1, d);
    if (r == 9) return make_tick(1'b1, 1'b1, 1'b0, d);
    if (r >= 96) return make_tick(1'($urandom), 1'($urandom), 1'($urandom), d);
    return make_tick(1'b1, 1'b1, 1'b1, d);
  endfunction

  task automatic send_tick(input tick_t t);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, t};
    do @(posedge clk); while (!s_tready);
    pins_q.push_back(step_cpu(t));
  endtask

  task automatic run_op(input logic [7:0] d);
    send_tick(make_tick(1'b1, 1'b1, 1'b1, d));
  endtask

  task automatic test_reset_sequence();
    repeat (8) run_op(8'h00);
    run_op(8'h00);
    run_op(8'h80);
  endtask

  task automatic test_opcodes();
    run_op(OP_NOP);
    run_op(OP_DEX);
    run_op(OP_LDX_IMM); run_op(8'h00);
    run_op(OP_BNE);     run_op(8'h05);
    run_op(OP_LDA_IMM); run_op(8'h80);
    run_op(OP_BNE);     run_op(8'h80);
    run_op(OP_LDX_IMM); run_op(8'h01);
    run_op(OP_BNE);     run_op(8'h7F);
    run_op(OP_DEX);
    run_op(OP_JMP_ABS); run_op(8'hFE); run_op(8'hFF);
    run_op(OP_LDA_IMM); run_op(8'hFF);
    run_op(OP_STA_ABS); run_op(8'h34); run_op(8'h12); run_op(8'h00);
    run_op(OP_LDA_ABS); run_op(8'hCD); run_op(8'hAB); run_op(8'h00);
    run_op(8'hFF);
  endtask

  task automatic test_bus_control();
    send_tick(make_tick(1'b0, 1'b1, 1'b1, 8'hFF));
    send_tick(make_tick(1'b1, 1'b0, 1'b1, OP_DEX));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 8'hFF));
    send_tick(make_tick(1'b1, 1'b0, 1'b0, 8'h00));
    send_tick(make_tick(1'b1, 1'b1, 1'b0, 8'hAA));
  endtask

  task automatic test_random_program();
    for (int i = 0; i < 850; i++) begin
      no_gaps = (i >= 300 && i < 400);
      send_tick(random_tick());
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    no_gaps  = 1'b1;
    repeat (40) send_tick(random_tick());
    no_gaps  = 1'b0;
  endtask

  // result side
  initial begin
    int unsigned stall;
    wait (!rst);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (80) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        stall = no_gaps ? 0 : $urandom_range(0, 5);
        if (stall != 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  always @(posedge clk) begin
    pins_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = pins_t'(m_tdata[28:0]);
      if (pins_q.size() == 0) begin
        report_mismatch("unexpected item", m_tdata, 0);
      end else begin
        want = pins_q.pop_front();
        if (got.address !== want.address)
          report_mismatch("address", got.address, want.address);
        if (got.read_not_write !== want.read_not_write)
          report_mismatch("read_not_write", got.read_not_write, want.read_not_write);
        if (got.sync !== want.sync)
          report_mismatch("sync", got.sync, want.sync);
        if (got.vector_pull_n !== want.vector_pull_n)
          report_mismatch("vector_pull_n", got.vector_pull_n, want.vector_pull_n);
        if (got.data_out !== want.data_out)
          report_mismatch("data_out", got.data_out, want.data_out);
        if (got.drive_data !== want.drive_data)
          report_mismatch("drive_data", got.drive_data, want.drive_data);
        if (got.bus_released !== want.bus_released)
          report_mismatch("bus_released", got.bus_released, want.bus_released);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    acc_r      = 8'h00;
    x_r        = 8'h00;
    flags_r    = STATUS_RESET;
    pc_r       = 16'h0000;
    bus_addr_r = VEC_LO_ADDR;
    eff_addr_r = 16'h0000;
    opcode_r   = 8'h00;
    wait_cnt_r = RESET_WAIT_TICKS;
    phase_r    = PH_RES_HOLD;
    read_r     = 1'b1;
    sync_r     = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_sequence();
    test_opcodes();
    test_bus_control();
    test_random_program();
    test_backpressure();
    s_tvalid <= 1'b0;
    while (pins_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
